### design/e2n_avg_pkg.sv
package e2n_avg_pkg;

    // field widths fixed by the stream format
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 12;
    localparam int VALUE_W     = 32;
    localparam int NODE_CNT_W  = 13;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    // node sum accumulator, signed, saturating
    localparam int SUM_W  = 40;
    // divider steps run from SUM_W down to zero
    localparam int STEP_W = $clog2(SUM_W + 1);

    // parameter defaults
    localparam int DEF_NODES     = 4096;
    localparam int DEF_MAX_SHARE = 255;

    // operation codes carried on the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_ACC   = 2'd0,
        OP_FIX   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

endpackage

### design/element_to_node_average_unit.sv
// channel   dir  signals                        contents
// s_axis    in   tvalid tready tdata[47:0] tuser  tdata: node_index, value_in; tuser: op
// m_axis    out  tvalid tready tdata[31:0] tuser  tdata: node_value; tuser: is_empty, is_fixed
// cfg       in   cfg_we cfg_wdata[12:0]          node_count, written on any edge with cfg_we
//
// accumulate and fix: one request per cycle while no read or clear holds the input; node memory
//   read-modify-write over two stages with the last write forwarded to the modify stage
// read: the result comes from the one-bit-per-step divider; the next request is
//   taken once the result sits in the output register, even while that result waits
// clear: min(node_count, NODES) memory entries written, one per cycle
// reset: a clearing pass writes all NODES entries before any request is taken
// stalls: output back-pressure holds the divider result, and with it s_axis_tready; configuration is taken at any time
module element_to_node_average_unit #(
    parameter int NODES     = e2n_avg_pkg::DEF_NODES,
    parameter int MAX_SHARE = e2n_avg_pkg::DEF_MAX_SHARE
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] node_index, [43:12] value_in, [47:44] zero
    input  logic [e2n_avg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] op
    input  logic [e2n_avg_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] node_value
    output logic [e2n_avg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] is_empty, [1] is_fixed
    output logic [e2n_avg_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    input  logic                                 cfg_we,
    input  logic [e2n_avg_pkg::NODE_CNT_W-1:0]   cfg_wdata
);
    import e2n_avg_pkg::*;

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW = AW + 1;
    localparam int CW = (MAX_SHARE > 1) ? $clog2(MAX_SHARE + 1) : 1;

    typedef struct packed {
        logic                 fixed;
        logic [CW-1:0]        count;
        logic [SUM_W-1:0]     sum;
    } entry_t;

    typedef enum logic [2:0] {
        S_INIT  = 3'b001,
        S_RUN   = 3'b010,
        S_CLEAR = 3'b100
    } state_t;

    // ---------------------------------------------------------------- registers
    state_t            state_reg, state_next;
    logic [PW-1:0]     clr_pos_reg, clr_pos_next;
    logic [PW-1:0]     clr_end_reg, clr_end_next;
    logic [NODE_CNT_W-1:0] node_count_reg;

    logic              p_valid_reg;
    op_t               p_op_reg;
    logic [AW-1:0]     p_addr_reg;
    logic              p_inr_reg;
    logic [VALUE_W-1:0] p_value_reg;

    entry_t            mem_rdata_reg;
    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    entry_t            fwd_data_reg;

    logic              dv_busy_reg, dv_busy_next;
    logic [STEP_W-1:0] dv_step_reg, dv_step_next;
    logic [SUM_W-1:0]  dv_quo_reg, dv_quo_next;
    logic [CW-1:0]     dv_rem_reg, dv_rem_next;
    logic [CW-1:0]     dv_den_reg, dv_den_next;
    logic              dv_neg_reg, dv_neg_next;
    logic              dv_empty_reg, dv_empty_next;
    logic              dv_fixed_reg, dv_fixed_next;

    logic              out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_data_reg;
    logic              out_empty_reg;
    logic              out_fixed_reg;

    entry_t            mem [NODES];

    // ---------------------------------------------------------------- input decode
    logic              in_accept;
    logic [INDEX_W-1:0] in_index;
    logic [AW+INDEX_W-1:0] in_index_ext;
    logic [AW-1:0]     in_addr;
    logic              in_inr;

    assign in_index     = s_axis_tdata[INDEX_W-1:0];
    assign in_index_ext = {{AW{1'b0}}, in_index};
    assign in_addr      = in_index_ext[AW-1:0];
    assign in_inr       = 32'(in_index) < 32'(NODES);

    // new requests only while running, the divider is free and no read or clear is in flight
    assign s_axis_tready = (state_reg == S_RUN) && !dv_busy_reg
        && !(p_valid_reg && (p_op_reg == OP_READ || p_op_reg == OP_CLEAR));
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------- modify stage
    entry_t            cur;
    logic [SUM_W:0]    acc_wide;
    logic [SUM_W-1:0]  acc_sat;
    logic [SUM_W-1:0]  cur_mag;
    logic              acc_ok;

    // forward the write that landed on the same edge as this entry's read
    assign cur = (fwd_valid_reg && fwd_addr_reg == p_addr_reg) ? fwd_data_reg : mem_rdata_reg;

    assign acc_ok   = p_inr_reg && !cur.fixed && (cur.count < CW'(MAX_SHARE));
    assign acc_wide = {cur.sum[SUM_W-1], cur.sum}
        + {{(SUM_W + 1 - VALUE_W){p_value_reg[VALUE_W-1]}}, p_value_reg};
    assign cur_mag  = cur.sum[SUM_W-1] ? (~cur.sum + SUM_W'(1)) : cur.sum;

    // saturate at the signed sum bounds
    always_comb
    begin
        if (acc_wide[SUM_W] != acc_wide[SUM_W-1])
        begin
            acc_sat = acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_wide[SUM_W-1:0];
        end
    end

    // ---------------------------------------------------------------- memory write select
    logic              walk_active;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    entry_t            mem_wdata;

    assign walk_active = (state_reg != S_RUN) && (clr_pos_reg != clr_end_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = p_addr_reg;
        mem_wdata = '0;
        if (walk_active)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_pos_reg[AW-1:0];
        end
        else if (p_valid_reg)
        begin
            case (p_op_reg)
                OP_ACC:
                begin
                    mem_we          = acc_ok;
                    mem_wdata.fixed = 1'b0;
                    mem_wdata.count = cur.count + CW'(1);
                    mem_wdata.sum   = acc_sat;
                end
                OP_FIX:
                begin
                    mem_we          = p_inr_reg;
                    mem_wdata.fixed = 1'b1;
                    mem_wdata.sum   = {{(SUM_W - VALUE_W){p_value_reg[VALUE_W-1]}}, p_value_reg};
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    // node memory, one write and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[in_addr];
    end

    // ---------------------------------------------------------------- walk control
    logic [31:0]       nc_ext;
    logic [PW-1:0]     clear_end;

    assign nc_ext    = 32'(node_count_reg);
    assign clear_end = (nc_ext > 32'(NODES)) ? PW'(NODES) : PW'(nc_ext);

    always_comb
    begin
        state_next   = state_reg;
        clr_pos_next = clr_pos_reg;
        clr_end_next = clr_end_reg;
        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                if (walk_active)
                begin
                    clr_pos_next = clr_pos_reg + PW'(1);
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (p_valid_reg && p_op_reg == OP_CLEAR)
                begin
                    state_next   = S_CLEAR;
                    clr_pos_next = '0;
                    clr_end_next = clear_end;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // ---------------------------------------------------------------- divider
    logic [CW:0]       dv_shift;
    logic              dv_ge;
    logic              dv_done;
    logic              out_load;
    logic [SUM_W-1:0]  dv_quo_neg;

    assign dv_shift   = {dv_rem_reg, dv_quo_reg[SUM_W-1]};
    assign dv_ge      = dv_shift >= {1'b0, dv_den_reg};
    assign dv_done    = dv_busy_reg && (dv_step_reg == '0);
    assign out_load   = dv_done && (!out_valid_reg || m_axis_tready);
    assign dv_quo_neg = ~dv_quo_reg + SUM_W'(1);

    always_comb
    begin
        dv_busy_next  = dv_busy_reg;
        dv_step_next  = dv_step_reg;
        dv_quo_next   = dv_quo_reg;
        dv_rem_next   = dv_rem_reg;
        dv_den_next   = dv_den_reg;
        dv_neg_next   = dv_neg_reg;
        dv_empty_next = dv_empty_reg;
        dv_fixed_next = dv_fixed_reg;
        if (p_valid_reg && p_op_reg == OP_READ)
        begin
            // take the read: immediate answer or start the long division
            dv_busy_next  = 1'b1;
            dv_rem_next   = '0;
            dv_den_next   = cur.count;
            dv_neg_next   = 1'b0;
            dv_empty_next = 1'b0;
            dv_fixed_next = 1'b0;
            dv_step_next  = '0;
            if (!p_inr_reg || (!cur.fixed && cur.count == '0))
            begin
                dv_quo_next   = '0;
                dv_empty_next = 1'b1;
            end
            else if (cur.fixed)
            begin
                dv_quo_next   = cur.sum;
                dv_fixed_next = 1'b1;
            end
            else
            begin
                dv_quo_next  = cur_mag;
                dv_neg_next  = cur.sum[SUM_W-1];
                dv_step_next = STEP_W'(SUM_W);
            end
        end
        else if (dv_busy_reg && dv_step_reg != '0)
        begin
            // one quotient bit per step
            dv_step_next = dv_step_reg - STEP_W'(1);
            dv_quo_next  = {dv_quo_reg[SUM_W-2:0], dv_ge};
            dv_rem_next  = dv_ge ? CW'(dv_shift - {1'b0, dv_den_reg}) : dv_shift[CW-1:0];
        end
        else if (out_load)
        begin
            dv_busy_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_fixed_reg, out_empty_reg};

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            clr_pos_reg    <= '0;
            clr_end_reg    <= PW'(NODES);
            node_count_reg <= NODE_CNT_W'(NODES);
            p_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            dv_busy_reg    <= 1'b0;
            dv_step_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_pos_reg   <= clr_pos_next;
            clr_end_reg   <= clr_end_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            p_valid_reg   <= in_accept;
            fwd_valid_reg <= mem_we;
            dv_busy_reg   <= dv_busy_next;
            dv_step_reg   <= dv_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_op_reg    <= op_t'(s_axis_tuser);
            p_addr_reg  <= in_addr;
            p_inr_reg   <= in_inr;
            p_value_reg <= s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W];
        end
        fwd_addr_reg <= mem_waddr;
        fwd_data_reg <= mem_wdata;
        dv_quo_reg   <= dv_quo_next;
        dv_rem_reg   <= dv_rem_next;
        dv_den_reg   <= dv_den_next;
        dv_neg_reg   <= dv_neg_next;
        dv_empty_reg <= dv_empty_next;
        dv_fixed_reg <= dv_fixed_next;
        if (out_load)
        begin
            out_data_reg  <= dv_neg_reg ? dv_quo_neg[VALUE_W-1:0] : dv_quo_reg[VALUE_W-1:0];
            out_empty_reg <= dv_empty_reg;
            out_fixed_reg <= dv_fixed_reg;
        end
    end

`ifndef SYNTHESIS
    // a read reaching the modify stage always finds the divider free
    assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && p_op_reg == OP_READ) |-> !dv_busy_reg)
        else $error("read reached modify stage while divider busy");

    // no request is in the modify stage while a walk owns the memory port
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RUN) |-> !p_valid_reg)
        else $error("request in flight during clear walk");

    // the walk never runs past its end
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RUN) |-> (clr_pos_reg <= clr_end_reg))
        else $error("clear walk overran its end");

    // division steps only count while the divider holds a job
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_step_reg != '0) |-> dv_busy_reg)
        else $error("divider stepping while idle");

    // a new result only appears out of a busy divider
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(dv_busy_reg))
        else $error("result without a divider job");
`endif

endmodule

### test/element_to_node_average_unit_tb.sv
`timescale 1ns / 1ps

module element_to_node_average_unit_tb;
    import e2n_avg_pkg::*;

    localparam int NODES_TB      = DEF_NODES;
    localparam int SHARE_CAP     = DEF_MAX_SHARE;
    localparam int HOT_NODES     = 48;
    localparam int HOLD_CYCLES   = 800;
    localparam int CLEAR_SETTLE  = DEF_NODES + 64;
    localparam int DRAIN_CYCLES  = 3 * (SUM_W + 3);
    localparam int CYCLE_LIMIT   = 1000000;
    localparam longint SUM_HI    = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO    = -(longint'(1) <<< (SUM_W - 1));

    // receiver stall styles
    localparam int SINK_FREE     = 0;
    localparam int SINK_COIN     = 1;
    localparam int SINK_MOSTLY   = 2;
    localparam int SINK_PERIODIC = 3;

    typedef struct packed {
        logic [VALUE_W-1:0] node_value;
        logic               is_empty;
        logic               is_fixed;
    } node_result_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] node;
        logic [VALUE_W-1:0] value;
        logic               typed;
        node_result_t       want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   cfg_we = 1'b0;
    logic [NODE_CNT_W-1:0]  cfg_wdata = '0;

    // node averaging mirror
    longint      node_sum_tbl [NODES_TB];
    int unsigned node_share_tbl [NODES_TB];
    bit          node_pinned_tbl [NODES_TB];
    int unsigned clear_span;

    node_result_t expected_reads [$];
    stim_row_t    directed_rows [$];

    int unsigned mismatches = 0;
    int unsigned reads_checked = 0;
    int unsigned requests_sent = 0;
    int unsigned settings_tried = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          steady_feed = 1'b0;
    bit          hold_off_pending = 1'b0;
    bit          hold_off_served = 1'b0;

    element_to_node_average_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // apply one request to the mirror, return 1 when it yields a result
    function automatic bit predict_request(input op_t op, input logic [INDEX_W-1:0] idx,
            input logic [VALUE_W-1:0] val, output node_result_t res);
        longint      v;
        longint      s;
        int unsigned n;
        int unsigned i;
        bit          in_range;
        v = longint'($signed(val));
        in_range = int'(idx) < NODES_TB;
        res = '0;
        res.is_empty = 1'b1;
        case (op)
            OP_ACC:
            begin
                if (in_range && !node_pinned_tbl[idx] && node_share_tbl[idx] < SHARE_CAP)
                begin
                    s = node_sum_tbl[idx] + v;
                    if (s > SUM_HI)
                        s = SUM_HI;
                    if (s < SUM_LO)
                        s = SUM_LO;
                    node_sum_tbl[idx] = s;
                    node_share_tbl[idx] = node_share_tbl[idx] + 1;
                end
                return 1'b0;
            end
            OP_FIX:
            begin
                if (in_range)
                begin
                    node_sum_tbl[idx] = v;
                    node_share_tbl[idx] = 0;
                    node_pinned_tbl[idx] = 1'b1;
                end
                return 1'b0;
            end
            OP_CLEAR:
            begin
                n = (clear_span > NODES_TB) ? NODES_TB : clear_span;
                for (i = 0; i < n; i++)
                begin
                    node_sum_tbl[i] = 0;
                    node_share_tbl[i] = 0;
                    node_pinned_tbl[i] = 1'b0;
                end
                return 1'b0;
            end
            default:
            begin
                if (in_range)
                begin
                    if (node_pinned_tbl[idx])
                    begin
                        s = node_sum_tbl[idx];
                        res.node_value = s[VALUE_W-1:0];
                        res.is_empty = 1'b0;
                        res.is_fixed = 1'b1;
                    end
                    else if (node_share_tbl[idx] != 0)
                    begin
                        // signed division truncates toward zero
                        s = node_sum_tbl[idx] / longint'(node_share_tbl[idx]);
                        res.node_value = s[VALUE_W-1:0];
                        res.is_empty = 1'b0;
                    end
                end
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
            input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // offer one request in bursts with random gaps, then record what it should return
    task automatic push_request(input op_t op, input logic [INDEX_W-1:0] idx,
            input logic [VALUE_W-1:0] val, input bit typed, input node_result_t want);
        node_result_t got;
        bit           has_result;
        if (!steady_feed && burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left != 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, val, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
        has_result = predict_request(op, idx, val, got);
        if (has_result)
            expected_reads.push_back(typed ? want : got);
    endtask

    // random request, mostly on a small set of nodes
    task automatic push_random(input int unsigned read_pct);
        op_t                op;
        logic [INDEX_W-1:0] idx;
        int unsigned        pick;
        node_result_t       none;
        pick = $urandom_range(0, 99);
        if (pick < read_pct)
            op = OP_READ;
        else if (pick < read_pct + 8)
            op = OP_FIX;
        else if (pick < read_pct + 11)
            op = OP_CLEAR;
        else
            op = OP_ACC;
        if ($urandom_range(0, 4) == 0)
            idx = INDEX_W'($urandom_range(0, NODES_TB - 1));
        else
            idx = INDEX_W'($urandom_range(0, HOT_NODES - 1));
        none = '0;
        push_request(op, idx, $urandom(), 1'b0, none);
    endtask

    // drain, let any clear finish, then write node_count
    task automatic settle_and_configure(input logic [NODE_CNT_W-1:0] setting);
        s_axis_tvalid <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (CLEAR_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(posedge clk);
        cfg_we <= 1'b0;
        clear_span = 32'(setting);
        settings_tried++;
    endtask

    function automatic void add_row(input op_t op, input logic [INDEX_W-1:0] node,
            input logic [VALUE_W-1:0] value, input bit typed,
            input logic [VALUE_W-1:0] want_value, input bit want_empty, input bit want_fixed);
        stim_row_t r;
        r.op = op;
        r.node = node;
        r.value = value;
        r.typed = typed;
        r.want.node_value = want_value;
        r.want.is_empty = want_empty;
        r.want.is_fixed = want_fixed;
        directed_rows.push_back(r);
    endfunction

    // receiver pacing with one long hold-off on request
    initial
    begin : sink_pacing
        int unsigned style;
        int unsigned style_left;
        int unsigned tick;
        style = SINK_FREE;
        style_left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off_pending && !hold_off_served)
            begin
                hold_off_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (style_left == 0)
            begin
                style = $urandom_range(SINK_FREE, SINK_PERIODIC);
                style_left = $urandom_range(16, 96);
            end
            style_left--;
            case (style)
                SINK_FREE:   m_axis_tready <= 1'b1;
                SINK_COIN:   m_axis_tready <= ($urandom_range(0, 1) != 0);
                SINK_MOSTLY: m_axis_tready <= ($urandom_range(0, 4) != 0);
                default:     m_axis_tready <= ((tick % 7) < 3);
            endcase
        end
    end

    // compare each result with the oldest pending read
    always @(posedge clk)
    begin : result_check
        node_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            reads_checked++;
            if (expected_reads.size() == 0)
                report_mismatch("result with no read pending", m_axis_tdata, '0);
            else
            begin
                want = expected_reads.pop_front();
                if (m_axis_tdata !== want.node_value)
                    report_mismatch("node_value", m_axis_tdata, want.node_value);
                if (m_axis_tuser[0] !== want.is_empty)
                    report_mismatch("is_empty", 32'(m_axis_tuser[0]), 32'(want.is_empty));
                if (m_axis_tuser[1] !== want.is_fixed)
                    report_mismatch("is_fixed", 32'(m_axis_tuser[1]), 32'(want.is_fixed));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reads pending", cycle_count,
                     expected_reads.size());
            $display("element_to_node_average_unit_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int           i;
        int unsigned  sat_node;
        node_result_t none;
        none = '0;
        for (i = 0; i < NODES_TB; i++)
        begin
            node_sum_tbl[i] = 0;
            node_share_tbl[i] = 0;
            node_pinned_tbl[i] = 1'b0;
        end
        clear_span = NODES_TB;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows at the reset node_count
        add_row(OP_READ,  12'd0,    32'h0000_0000, 1, 32'h0000_0000, 1, 0);
        add_row(OP_READ,  12'd4095, 32'hFFFF_FFFF, 1, 32'h0000_0000, 1, 0);
        add_row(OP_ACC,   12'd5,    32'h7FFF_FFFF, 0, 32'h0, 0, 0);
        add_row(OP_ACC,   12'd5,    32'h7FFF_FFFF, 0, 32'h0, 0, 0);
        add_row(OP_ACC,   12'd5,    32'h0000_0001, 0, 32'h0, 0, 0);
        add_row(OP_READ,  12'd5,    32'h0000_0000, 0, 32'h0, 0, 0);
        add_row(OP_ACC,   12'd6,    32'h8000_0000, 0, 32'h0, 0, 0);
        add_row(OP_ACC,   12'd6,    32'hFFFF_FFFF, 0, 32'h0, 0, 0);
        add_row(OP_READ,  12'd6,    32'h0000_0000, 0, 32'h0, 0, 0);
        add_row(OP_ACC,   12'd7,    32'hFFFF_FFFD, 0, 32'h0, 0, 0);
        add_row(OP_ACC,   12'd7,    32'hFFFF_FFFE, 0, 32'h0, 0, 0);
        add_row(OP_READ,  12'd7,    32'h0000_0000, 0, 32'h0, 0, 0);
        add_row(OP_FIX,   12'd8,    32'h8000_0000, 0, 32'h0, 0, 0);
        add_row(OP_READ,  12'd8,    32'h0000_0000, 1, 32'h8000_0000, 0, 1);
        add_row(OP_ACC,   12'd8,    32'h1234_5678, 0, 32'h0, 0, 0);
        add_row(OP_FIX,   12'd8,    32'h7FFF_FFFF, 0, 32'h0, 0, 0);
        add_row(OP_READ,  12'd8,    32'h0000_0000, 1, 32'h7FFF_FFFF, 0, 1);
        add_row(OP_FIX,   12'd5,    32'hFFFF_0000, 0, 32'h0, 0, 0);
        add_row(OP_READ,  12'd5,    32'h0000_0000, 1, 32'hFFFF_0000, 0, 1);
        add_row(OP_FIX,   12'd4095, 32'h0001_0000, 0, 32'h0, 0, 0);
        add_row(OP_READ,  12'd4095, 32'h0000_0000, 1, 32'h0001_0000, 0, 1);
        add_row(OP_CLEAR, 12'd0,    32'h0000_0000, 0, 32'h0, 0, 0);
        add_row(OP_READ,  12'd8,    32'h0000_0000, 1, 32'h0000_0000, 1, 0);
        add_row(OP_READ,  12'd4095, 32'h0000_0000, 1, 32'h0000_0000, 1, 0);
        add_row(OP_ACC,   12'd8,    32'h0002_8000, 0, 32'h0, 0, 0);
        add_row(OP_READ,  12'd8,    32'h0000_0000, 0, 32'h0, 0, 0);
        for (i = 0; i < directed_rows.size(); i++)
            push_request(directed_rows[i].op, directed_rows[i].node, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].want);

        // long output stall while reads keep coming, block must back up
        settle_and_configure(13'd1);
        hold_off_pending = 1'b1;
        steady_feed = 1'b1;
        for (i = 0; i < 12; i++)
            push_random(70);
        steady_feed = 1'b0;

        // clear that touches nothing
        settle_and_configure(13'd0);
        for (i = 0; i < 35; i++)
            push_random(35);

        // partial clear over part of the hot nodes
        settle_and_configure(13'd37);
        for (i = 0; i < 40; i++)
            push_random(40);

        // oversized node_count, then drive one node past its share limit
        settle_and_configure(13'd8191);
        push_request(OP_CLEAR, '0, $urandom(), 1'b0, none);
        sat_node = $urandom_range(0, HOT_NODES - 1);
        for (i = 0; i < SHARE_CAP + 3; i++)
            push_request(OP_ACC, INDEX_W'(sat_node), $urandom(), 1'b0, none);
        push_request(OP_READ, INDEX_W'(sat_node), $urandom(), 1'b0, none);
        for (i = 0; i < 20; i++)
            push_random(40);

        // back-to-back feed
        settle_and_configure(13'd300);
        steady_feed = 1'b1;
        for (i = 0; i < 30; i++)
            push_random(35);
        steady_feed = 1'b0;

        settle_and_configure(13'd4096);
        for (i = 0; i < 40; i++)
            push_random(40);

        // wait for every read to come back, then let the pipe drain
        s_axis_tvalid <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests, checked %0d read results, %0d mismatches",
                 requests_sent, reads_checked, mismatches);
        $display("covered %0d node_count settings, a long output stall and share saturation",
                 settings_tried);
        if (mismatches == 0)
            $display("element_to_node_average_unit_tb OK");
        else
            $display("element_to_node_average_unit_tb NOT OK");
        $finish;
    end

endmodule

### element_to_node_average_unit.f
design/e2n_avg_pkg.sv
design/element_to_node_average_unit.sv
test/element_to_node_average_unit_tb.sv
